// ===== src/rcu_pkg.sv =====
// Shared types, codes and constants of the root counter unit.
`default_nettype none
package rcu_pkg;

	localparam int unsigned RCU_CHANNELS = 3;

	// Channel that keeps running in sync modes one and two.
	localparam int unsigned SYNC_FREE_CH = 2;

	localparam int unsigned CNT_W   = 32;
	localparam int unsigned TGT_W   = 16;
	localparam int unsigned MODE_W  = 10;
	localparam int unsigned CYC_W   = 10;
	localparam int unsigned DATA_W  = 16;
	localparam int unsigned OFS_W   = 6;

	localparam logic [TGT_W-1:0] FULL_COUNT = 16'hFFFF;

	// Action codes.
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;

	// Register slots within a channel.
	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	// Sync mode values that halt the free channel while sync is set.
	localparam logic [1:0] SMODE_HALT_A = 2'd0;
	localparam logic [1:0] SMODE_HALT_B = 2'd3;

	// Mode setting bit positions.
	localparam int unsigned MODE_SYNC_BIT = 0;
	localparam int unsigned MODE_RST_TGT_BIT = 3;

	// Per-channel control for one transaction.
	typedef struct packed {
		logic              tick;
		logic              wr;
		logic              rd;
		logic [1:0]        reg_sel;
		logic [DATA_W-1:0] wdata;
		logic [CYC_W-1:0]  cycles;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== src/rcu_in_if.sv =====
// Request channel: valid/ready handshake carrying one bus or tick item.
`default_nettype none
interface rcu_in_if
	import rcu_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [OFS_W-1:0]  reg_offset;
	logic [DATA_W-1:0] write_data;
	logic [CYC_W-1:0]  cycles;

	modport source (output valid, action, reg_offset, write_data, cycles, input ready);
	modport sink (input valid, action, reg_offset, write_data, cycles, output ready);
endinterface
`default_nettype wire

// ===== src/rcu_out_if.sv =====
// Response channel: valid/ready handshake carrying one read result.
`default_nettype none
interface rcu_out_if
	import rcu_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;

	modport source (output valid, read_data, input ready);
	modport sink (input valid, read_data, output ready);
endinterface
`default_nettype wire

// ===== src/three_channel_root_counter_unit.sv =====
// Top level of the three-channel root counter unit.
//
//   channel | direction | payload                                   | handshake
//   --------+-----------+-------------------------------------------+------------
//   req     | in        | action, reg_offset, write_data, cycles    | valid/ready
//   rsp     | out       | read_data                                 | valid/ready
//
// Every transaction on req yields exactly one transaction on rsp; it passes through the input
// register (s1) and then the response register. A new request is taken every clock unless rsp
// stalls; s1 and the response register each hold one item, so throughput is one per cycle.
// All channel state updates and the register read happen in the single cycle an item
// leaves s1; the counter add/compare/subtract of each channel sets that path.
// arst_n clears both stages and loads every channel with its power-on values at once.
// A stalled rsp holds the response register and then s1; req.ready drops only when both are full.
`default_nettype none
module three_channel_root_counter_unit
	import rcu_pkg::*;
#(
	parameter int unsigned CHANNELS = RCU_CHANNELS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rcu_in_if.sink    req,
	rcu_out_if.source rsp
);

	// Input stage.
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [OFS_W-1:0]  offset_s1;
	logic [DATA_W-1:0] wdata_s1;
	logic [CYC_W-1:0]  cycles_s1;

	// Response register.
	logic              rsp_valid_q;
	logic [DATA_W-1:0] read_data_q;

	logic              advance;
	logic              fire_s1;
	logic [1:0]        ch_sel;
	logic [1:0]        reg_sel;
	logic [DATA_W-1:0] rd_data [CHANNELS];
	logic [DATA_W-1:0] rd_merge;

	// Drain s1 whenever the response register is empty or being taken.
	assign advance   = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && advance;
	assign req.ready = !valid_s1 || advance;

	assign ch_sel  = offset_s1[5:4];
	assign reg_sel = offset_s1[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// Capture the payload on every accepted transaction.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			offset_s1 <= req.reg_offset;
			wdata_s1  <= req.write_data;
			cycles_s1 <= req.cycles;
		end
	end

	// One channel per index; an index with no channel reads zero and drops writes.
	for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
		ctrl_t ctrl;
		logic  hit;

		assign hit          = (ch_sel == 2'(i));
		assign ctrl.tick    = fire_s1 && (action_s1 == ACT_TICK);
		assign ctrl.wr      = fire_s1 && (action_s1 == ACT_WRITE) && hit;
		assign ctrl.rd      = (action_s1 == ACT_READ) && hit;
		assign ctrl.reg_sel = reg_sel;
		assign ctrl.wdata   = wdata_s1;
		assign ctrl.cycles  = cycles_s1;

		rcu_channel #(
			.CH_INDEX(i)
		) u_channel (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.rd_data (rd_data[i])
		);
	end

	// At most one channel drives a nonzero read word.
	always_comb begin
		rd_merge = '0;
		for (int unsigned k = 0; k < CHANNELS; k++) begin
			rd_merge = rd_merge | rd_data[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			read_data_q <= rd_merge;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = read_data_q;

	// Assertions.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid_q |-> req.ready)
		else $error("request stalled with an empty response register");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(action_s1) && $stable(offset_s1)
			&& $stable(wdata_s1) && $stable(cycles_s1))
		else $error("input stage changed while stalled");

	a_non_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && action_s1 != ACT_READ |=> read_data_q == '0)
		else $error("non-read transaction returned nonzero data");

	a_s1_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> rsp_valid_q)
		else $error("item left the input stage without a response");

endmodule
`default_nettype wire

// ===== src/rcu_channel.sv =====
// One timer channel: counter, target, mode, sticky flags and register read.
`default_nettype none
module rcu_channel
	import rcu_pkg::*;
#(
	parameter int unsigned CH_INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ctrl_t             ctrl,
	output logic [DATA_W-1:0]      rd_data
);

	localparam bit SYNC_FREE = (CH_INDEX == SYNC_FREE_CH);
	localparam int unsigned EXT_W = CNT_W + 2;

	logic signed [CNT_W-1:0] counter_q;
	logic [TGT_W-1:0]        target_q;
	logic [MODE_W-1:0]       mode_q;
	logic                    irq_q;
	logic                    tgt_hit_q;
	logic                    ovf_q;

	logic                    sync;
	logic [1:0]              smode;
	logic                    runs;
	logic signed [EXT_W-1:0] old_x;
	logic signed [EXT_W-1:0] sum_x;
	logic signed [EXT_W-1:0] tgt_x;
	logic signed [EXT_W-1:0] full_x;
	logic signed [EXT_W-1:0] next_x;
	logic                    hit;
	logic                    ovf;

	assign sync  = mode_q[MODE_SYNC_BIT];
	assign smode = mode_q[2:1];
	assign runs  = !sync || (SYNC_FREE && smode != SMODE_HALT_A && smode != SMODE_HALT_B);

	always_comb begin
		old_x  = EXT_W'(counter_q);
		sum_x  = old_x + $signed({{(EXT_W-CYC_W){1'b0}}, ctrl.cycles});
		tgt_x  = $signed({{(EXT_W-TGT_W){1'b0}}, target_q});
		full_x = $signed({{(EXT_W-TGT_W){1'b0}}, FULL_COUNT});
		hit    = (old_x < tgt_x) && (sum_x >= tgt_x);
		ovf    = (sum_x >= full_x);
		next_x = sum_x;
		if (hit && mode_q[MODE_RST_TGT_BIT]) begin
			next_x = next_x - tgt_x;
		end
		if (ovf) begin
			next_x = next_x - full_x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			target_q  <= FULL_COUNT;
			mode_q    <= '0;
			irq_q     <= 1'b1;
			tgt_hit_q <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (ctrl.tick && runs) begin
			counter_q <= next_x[CNT_W-1:0];
			if (hit) begin
				tgt_hit_q <= 1'b1;
			end
			if (ovf) begin
				ovf_q <= 1'b1;
			end
		end else if (ctrl.wr) begin
			unique case (ctrl.reg_sel)
				REG_COUNT:  counter_q <= '0;
				REG_MODE: begin
					mode_q <= ctrl.wdata[MODE_W-1:0];
					irq_q  <= 1'b1;
				end
				REG_TARGET: target_q <= ctrl.wdata;
				default:    ;
			endcase
		end
	end

	always_comb begin
		rd_data = '0;
		if (ctrl.rd) begin
			unique case (ctrl.reg_sel)
				REG_COUNT:  rd_data = counter_q[DATA_W-1:0];
				REG_MODE:   rd_data = {3'b000, ovf_q, tgt_hit_q, irq_q, mode_q};
				REG_TARGET: rd_data = target_q;
				default:    rd_data = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the three-channel root counter unit.
`timescale 1ns / 100ps

module tb;
	import rcu_pkg::*;

	// Codes that the package leaves unnamed: the spare action, the missing
	// fourth channel and the empty register slot.
	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam logic [1:0] CH_ABSENT = 2'd3;
	localparam logic [1:0] REG_EMPTY = 2'd3;

	localparam int RANDOM_ITEMS = 950;
	localparam int RUN_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [1:0]        action;
		logic [OFS_W-1:0]  reg_offset;
		logic [DATA_W-1:0] write_data;
		logic [CYC_W-1:0]  cycles;
	} bus_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rcu_in_if  req_if ();
	rcu_out_if rsp_if ();

	three_channel_root_counter_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Items waiting to go out, and the read data each accepted item should return.
	bus_item_t         pending_q[$];
	logic [DATA_W-1:0] read_data_q[$];

	// Shadow copy of the timer state, advanced once per accepted transaction.
	logic signed [CNT_W-1:0] shadow_count [RCU_CHANNELS];
	logic [TGT_W-1:0]        shadow_target[RCU_CHANNELS];
	logic [MODE_W-1:0]       shadow_mode  [RCU_CHANNELS];
	logic                    shadow_irq   [RCU_CHANNELS];
	logic                    shadow_hit   [RCU_CHANNELS];
	logic                    shadow_ovf   [RCU_CHANNELS];

	int err_cnt = 0;
	int checked_cnt = 0;
	int tick_cnt = 0, read_cnt = 0, write_cnt = 0, spare_cnt = 0;
	int hit_events = 0, ovf_events = 0, negative_events = 0;
	int cycle_cnt = 0;

	task automatic add_item(input logic [1:0] act, input logic [OFS_W-1:0] ofs,
			input logic [DATA_W-1:0] wd, input logic [CYC_W-1:0] cyc);
		bus_item_t it;
		it.action = act;
		it.reg_offset = ofs;
		it.write_data = wd;
		it.cycles = cyc;
		pending_q.push_back(it);
	endtask

	// Channel 2 keeps running in sync modes one and two; the others halt on sync.
	function automatic logic channel_runs(int unsigned ch);
		logic       sync;
		logic [1:0] smode;
		sync = shadow_mode[ch][MODE_SYNC_BIT];
		smode = shadow_mode[ch][2:1];
		if (ch == SYNC_FREE_CH)
			return !sync || (smode != SMODE_HALT_A && smode != SMODE_HALT_B);
		return !sync;
	endfunction

	// Add the elapsed cycles, then apply the target and overflow drops, both
	// judged on the sum before either drop.
	function automatic void advance_channel(int unsigned ch, logic [CYC_W-1:0] cyc);
		longint sum, nxt, tgt, cy, full;
		cy = cyc;
		tgt = shadow_target[ch];
		full = FULL_COUNT;
		sum = shadow_count[ch];
		sum = sum + cy;
		nxt = sum;
		if (sum - cy < tgt && sum >= tgt) begin
			shadow_hit[ch] = 1'b1;
			hit_events++;
			if (shadow_mode[ch][MODE_RST_TGT_BIT])
				nxt = nxt - tgt;
		end
		if (sum >= full) begin
			nxt = nxt - full;
			shadow_ovf[ch] = 1'b1;
			ovf_events++;
		end
		if (nxt < 0)
			negative_events++;
		shadow_count[ch] = nxt[CNT_W-1:0];
	endfunction

	// Apply one transaction to the shadow state and return its read data.
	function automatic logic [DATA_W-1:0] apply_transaction(bus_item_t it);
		logic [1:0]        ch, rg;
		logic [DATA_W-1:0] rd;
		int unsigned       i;
		ch = it.reg_offset[5:4];
		rg = it.reg_offset[3:2];
		rd = '0;
		case (it.action)
			ACT_TICK: begin
				tick_cnt++;
				for (i = 0; i < RCU_CHANNELS; i++)
					if (channel_runs(i))
						advance_channel(i, it.cycles);
			end
			ACT_READ: begin
				read_cnt++;
				if (ch < RCU_CHANNELS) begin
					case (rg)
						REG_COUNT:  rd = shadow_count[ch][DATA_W-1:0];
						REG_MODE:   rd = {3'b000, shadow_ovf[ch], shadow_hit[ch],
								shadow_irq[ch], shadow_mode[ch]};
						REG_TARGET: rd = shadow_target[ch];
						default:    rd = '0;
					endcase
				end
			end
			ACT_WRITE: begin
				write_cnt++;
				if (ch < RCU_CHANNELS) begin
					case (rg)
						REG_COUNT: shadow_count[ch] = '0;
						REG_MODE: begin
							shadow_mode[ch] = it.write_data[MODE_W-1:0];
							shadow_irq[ch] = 1'b1;
						end
						REG_TARGET: shadow_target[ch] = it.write_data;
						default: ;
					endcase
				end
			end
			default: spare_cnt++;
		endcase
		return rd;
	endfunction

	// Driver: present items in bursts of random length, separated by random gaps.
	// Record the expected read data at the edge where a transaction is accepted.
	bus_item_t on_bus;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.action <= '0;
			req_if.reg_offset <= '0;
			req_if.write_data <= '0;
			req_if.cycles <= '0;
		end else begin
			if (req_if.valid && req_if.ready)
				read_data_q.push_back(apply_transaction(on_bus));
			// Hold the item while it is offered and not yet taken.
			if (!req_if.valid || req_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_if.valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					on_bus = pending_q.pop_front();
					req_if.valid <= 1'b1;
					req_if.action <= on_bus.action;
					req_if.reg_offset <= on_bus.reg_offset;
					req_if.write_data <= on_bus.write_data;
					req_if.cycles <= on_bus.cycles;
					if (burst_left == 0) begin
						// A third of the bursts run with no gap at all.
						burst_left = $urandom_range(1, 40);
						if ($urandom_range(0, 2) == 0)
							gap_left = 0;
						else if ($urandom_range(0, 4) == 0)
							gap_left = $urandom_range(4, 12);
						else
							gap_left = $urandom_range(1, 3);
					end else begin
						burst_left--;
					end
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each response against the oldest expectation and drive the
	// receiver's stall pattern. A new pattern style is drawn each time stall_phase wraps.
	logic [5:0] stall_phase;
	logic [1:0] stall_style;
	logic [DATA_W-1:0] want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_phase <= '0;
			stall_style <= '0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (read_data_q.size() == 0) begin
					$error("read_data: response with no request pending, actual %h",
						rsp_if.read_data);
					err_cnt++;
				end else begin
					want = read_data_q.pop_front();
					checked_cnt++;
					if (rsp_if.read_data !== want) begin
						$error("read_data mismatch: expected %h, actual %h",
							want, rsp_if.read_data);
						err_cnt++;
					end
				end
			end
			stall_phase <= stall_phase + 6'd1;
			if (stall_phase == '1)
				stall_style <= 2'($urandom_range(0, 3));
			case (stall_style)
				2'd0: rsp_if.ready <= 1'b1;
				2'd1: rsp_if.ready <= stall_phase[0];
				2'd2: rsp_if.ready <= ($urandom_range(0, 9) < 7);
				default: rsp_if.ready <= (stall_phase[4:0] > 5'd20);
			endcase
		end
	end

	// Watchdog: end the run if the traffic never drains.
	initial begin
		while (cycle_cnt < RUN_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** three_channel_root_counter_unit: FAILED **");
		$finish;
	end

	initial begin
		logic [1:0]        ch_r, rg_r, lo_r;
		logic [DATA_W-1:0] wd_r;
		logic [CYC_W-1:0]  cyc_r;
		int                pick, n, i;

		for (i = 0; i < RCU_CHANNELS; i++) begin
			shadow_count[i] = '0;
			shadow_target[i] = FULL_COUNT;
			shadow_mode[i] = '0;
			shadow_irq[i] = 1'b1;
			shadow_hit[i] = 1'b0;
			shadow_ovf[i] = 1'b0;
		end

		// Directed part: power-on values, the absent channel, the empty slot,
		// the spare action, target reload, sync halts in every channel flavor.
		add_item(ACT_READ, {2'd0, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_READ, {2'd0, REG_MODE, 2'b00}, 16'hFFFF, 10'h3FF);
		add_item(ACT_READ, {2'd0, REG_TARGET, 2'b11}, 16'h0000, 10'd0);
		add_item(ACT_READ, {CH_ABSENT, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_WRITE, {CH_ABSENT, REG_MODE, 2'b00}, 16'hFFFF, 10'd0);
		add_item(ACT_WRITE, {2'd1, REG_EMPTY, 2'b00}, 16'hFFFF, 10'd0);
		add_item(ACT_SPARE, 6'h3F, 16'hFFFF, 10'h3FF);
		add_item(ACT_WRITE, {2'd0, REG_TARGET, 2'b00}, 16'd100, 10'd0);
		add_item(ACT_WRITE, {2'd0, REG_MODE, 2'b00}, 16'hFFF8, 10'd0);
		add_item(ACT_WRITE, {2'd1, REG_MODE, 2'b00}, 16'h0001, 10'd0);
		add_item(ACT_WRITE, {2'd2, REG_MODE, 2'b00}, 16'h0003, 10'd0);
		add_item(ACT_TICK, 6'h00, 16'h0000, 10'd0);
		add_item(ACT_TICK, 6'h00, 16'h0000, 10'h3FF);
		add_item(ACT_READ, {2'd0, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_READ, {2'd0, REG_MODE, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_READ, {2'd1, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_READ, {2'd2, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_WRITE, {2'd2, REG_MODE, 2'b00}, 16'h0007, 10'd0);
		add_item(ACT_TICK, 6'h00, 16'h0000, 10'h3FF);
		add_item(ACT_READ, {2'd2, REG_COUNT, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_WRITE, {2'd2, REG_MODE, 2'b00}, 16'h0005, 10'd0);
		add_item(ACT_TICK, 6'h00, 16'h0000, 10'd5);
		add_item(ACT_READ, {2'd2, REG_MODE, 2'b00}, 16'h0000, 10'd0);
		add_item(ACT_WRITE, {2'd0, REG_COUNT, 2'b00}, 16'hFFFF, 10'd0);

		// Random part: mostly ticks and reads over the live channels, with writes
		// that keep sync mostly off and targets often small enough to be crossed.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			lo_r = 2'($urandom);
			ch_r = ($urandom_range(0, 19) == 0) ? CH_ABSENT : 2'($urandom_range(0, 2));
			rg_r = ($urandom_range(0, 14) == 0) ? REG_EMPTY : 2'($urandom_range(0, 2));
			wd_r = 16'($urandom);
			cyc_r = 10'($urandom);
			if (pick < 45) begin
				if ($urandom_range(0, 3) == 0)
					cyc_r = 10'($urandom_range(0, 15));
				add_item(ACT_TICK, {ch_r, rg_r, lo_r}, wd_r, cyc_r);
			end else if (pick < 73) begin
				add_item(ACT_READ, {ch_r, rg_r, lo_r}, wd_r, cyc_r);
			end else if (pick < 95) begin
				// Make counter clears rarer so counts have time to climb.
				if (rg_r == REG_COUNT && $urandom_range(0, 1) == 0)
					rg_r = REG_TARGET;
				if (rg_r == REG_MODE && $urandom_range(0, 9) < 7)
					wd_r[MODE_SYNC_BIT] = 1'b0;
				if (rg_r == REG_TARGET && $urandom_range(0, 1) == 0)
					wd_r = 16'($urandom_range(0, 3000));
				add_item(ACT_WRITE, {ch_r, rg_r, lo_r}, wd_r, cyc_r);
			end else begin
				add_item(ACT_SPARE, {ch_r, rg_r, lo_r}, wd_r, cyc_r);
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: wait for the last transaction to go in and its response to come back.
		while (pending_q.size() != 0 || req_if.valid)
			@(posedge clk);
		while (read_data_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d ticks, %0d reads, %0d writes, %0d spare actions; %0d responses checked.",
			tick_cnt, read_cnt, write_cnt, spare_cnt, checked_cnt);
		$display("Counters crossed a target %0d times, overflowed %0d times, went negative %0d times.",
			hit_events, ovf_events, negative_events);
		if (err_cnt == 0)
			$display("** three_channel_root_counter_unit: PASSED **");
		else
			$display("** three_channel_root_counter_unit: FAILED **");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rcu_pkg.sv
src/rcu_in_if.sv
src/rcu_out_if.sv
src/rcu_channel.sv
src/three_channel_root_counter_unit.sv
tb/tb.sv
